[design/cbsp_pkg.sv]
// Shared types, codes, constants and helper functions of the box stream parser.
package cbsp_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int TYPE_W   = 32;
    localparam int LEN_W    = 64;
    localparam int COUNT_W  = 16;
    localparam int ERR_W    = 3;
    localparam int HIDX_W   = 5;
    localparam int HLEN_W   = 6;
    localparam int PIDX_W   = 4;
    localparam int POS_W    = 2;

    // Header phase, one-hot
    typedef enum logic [4:0] {
        PH_SIZE    = 5'b00001,
        PH_TYPE    = 5'b00010,
        PH_LARGE   = 5'b00100,
        PH_EXT     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // Byte classification codes
    localparam logic [KIND_W-1:0] KIND_SIZE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TYPE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LARGE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd5;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_HEADER    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SIZE      = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_SIG   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_FTYP  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd5;

    // Box types
    localparam logic [TYPE_W-1:0] TYPE_UUID = 32'h7575_6964;
    localparam logic [TYPE_W-1:0] TYPE_SIG  = 32'h4A58_4C20;
    localparam logic [TYPE_W-1:0] TYPE_FTYP = 32'h6674_7970;

    // Header field lengths in bytes
    localparam logic [HIDX_W-1:0] SIZE_BYTES  = 5'd4;
    localparam logic [HIDX_W-1:0] TYPE_BYTES  = 5'd4;
    localparam logic [HIDX_W-1:0] LARGE_BYTES = 5'd8;
    localparam logic [HIDX_W-1:0] EXT_BYTES   = 5'd16;

    // Position of the box within the stream
    localparam logic [POS_W-1:0] POS_SIG  = 2'd0;
    localparam logic [POS_W-1:0] POS_FTYP = 2'd1;
    localparam logic [POS_W-1:0] POS_BARE = 2'd2;

    // Expected payload lengths of the signature and ftyp boxes
    localparam logic [HLEN_W:0] SIG_LEN  = 7'd4;
    localparam logic [HLEN_W:0] FTYP_LEN = 7'd12;

    localparam logic [PIDX_W-1:0]  PAY_IDX_MAX = 4'd15;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [LEN_W-1:0]   SIZE_LARGE  = 64'd1;

    // Parse state carried from byte to byte
    typedef struct packed {
        t_phase              phase;
        logic [HIDX_W-1:0]   hdr_idx;
        logic [LEN_W-1:0]    size_acc;
        logic [TYPE_W-1:0]   type_word;
        logic [HLEN_W-1:0]   hdr_len;
        logic [LEN_W-1:0]    pay_rem;
        logic                runs_to_end;
        logic [POS_W-1:0]    box_pos;
        logic [PIDX_W-1:0]   pay_idx;
        logic [COUNT_W-1:0]  box_cnt;
        logic [ERR_W-1:0]    err;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{
        phase:       PH_SIZE,
        hdr_idx:     '0,
        size_acc:    '0,
        type_word:   '0,
        hdr_len:     '0,
        pay_rem:     '0,
        runs_to_end: 1'b0,
        box_pos:     POS_SIG,
        pay_idx:     '0,
        box_cnt:     '0,
        err:         ERR_NONE
    };

    // One classified byte
    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic [KIND_W-1:0]   byte_kind;
        logic [TYPE_W-1:0]   box_type;
        logic                header_done;
        logic                size_given;
        logic [LEN_W-1:0]    payload_length;
        logic                box_done;
        logic [COUNT_W-1:0]  box_count;
        logic [ERR_W-1:0]    error_code;
        logic                stream_ok;
    } t_result;

    // Signature box payload, 0D 0A 87 0A
    function automatic logic [BYTE_W-1:0] sig_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] val;
        unique case (idx)
            2'd0:    val = 8'h0D;
            2'd1:    val = 8'h0A;
            2'd2:    val = 8'h87;
            default: val = 8'h0A;
        endcase
        return val;
    endfunction

    // ftyp payload, "jxl " 00 00 00 00 "jxl "; past the end holds the last byte
    function automatic logic [BYTE_W-1:0] ftyp_byte(input logic [PIDX_W-1:0] idx);
        logic [BYTE_W-1:0] val;
        unique case (idx)
            4'd0, 4'd8:               val = 8'h6A;
            4'd1, 4'd9:               val = 8'h78;
            4'd2, 4'd10:              val = 8'h6C;
            4'd4, 4'd5, 4'd6, 4'd7:   val = 8'h00;
            default:                  val = 8'h20;
        endcase
        return val;
    endfunction

    // Drop everything that belongs to the current box
    function automatic t_parse_state clear_box(input t_parse_state s);
        t_parse_state r;
        r             = s;
        r.phase       = PH_SIZE;
        r.hdr_idx     = '0;
        r.size_acc    = '0;
        r.type_word   = '0;
        r.hdr_len     = '0;
        r.pay_rem     = '0;
        r.runs_to_end = 1'b0;
        r.pay_idx     = '0;
        return r;
    endfunction

endpackage

[design/cbsp_if.sv]
// Channel interfaces of the box stream parser: byte requests, results, configuration.
interface cbsp_in_if import cbsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              stream_end;

    modport source (output valid, output stream_byte, output stream_end, input ready);
    modport sink   (input valid, input stream_byte, input stream_end, output ready);
endinterface

interface cbsp_out_if import cbsp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  data_byte;
    logic [KIND_W-1:0]  byte_kind;
    logic [TYPE_W-1:0]  box_type;
    logic               header_done;
    logic               size_given;
    logic [LEN_W-1:0]   payload_length;
    logic               box_done;
    logic [COUNT_W-1:0] box_count;
    logic [ERR_W-1:0]   error_code;
    logic               stream_ok;

    modport source (output valid, output data_byte, output byte_kind, output box_type,
                    output header_done, output size_given, output payload_length,
                    output box_done, output box_count, output error_code,
                    output stream_ok, input ready);
    modport sink   (input valid, input data_byte, input byte_kind, input box_type,
                    input header_done, input size_given, input payload_length,
                    input box_done, input box_count, input error_code,
                    input stream_ok, output ready);
endinterface

interface cbsp_cfg_if ();
    logic valid;
    logic ready;
    logic container_mode;

    modport source (output valid, output container_mode, input ready);
    modport sink   (input valid, input container_mode, output ready);
endinterface

[design/container_box_stream_parser_core.sv]
// Top level of the box stream parser: input register, parse state, result register.
//
// Takes a box-structured container stream one byte per request and returns one
// classification per byte, in order. A byte is held in the input register, the
// parse state and the result are worked out from it combinationally, and the
// result lands in the result register once it has room. One byte is taken every
// cycle as long as the result side keeps taking results; the rate is set by the
// update of the parse state (header byte counter, 64-bit size shift and payload
// down-counter). A new byte is taken while a finished result waits, if the input
// register is empty. container_mode resets to 1; the user must write it only while
// no byte is in flight, unenforced here; the configuration channel is always ready.
module container_box_stream_parser_core import cbsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbsp_in_if.sink    i_in,
    cbsp_out_if.source o_out,
    cbsp_cfg_if.sink   i_cfg
);

    logic              r_mode;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;
    t_parse_state      r_state;
    t_parse_state      w_next;
    t_result           w_result;
    logic              w_space;
    logic              w_adv;
    logic              w_in_ready;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.container_mode;
        end
    end

    // Input register: advance when the result register has room
    assign w_adv      = r_in_valid && w_space;
    assign w_in_ready = !r_in_valid || w_space;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_byte <= i_in.stream_byte;
            r_in_end  <= i_in.stream_end;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_adv) begin
            r_state <= w_next;
        end
    end

    cbsp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .i_mode   (r_mode),
        .o_next   (w_next),
        .o_result (w_result)
    );

    cbsp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_result (w_result),
        .o_space  (w_space),
        .o_out    (o_out)
    );

endmodule

[design/cbsp_step.sv]
// Per-byte parse step: next parse state and the classification of one byte.
module cbsp_step import cbsp_pkg::*; (
    input  t_parse_state      i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_end,
    input  logic              i_mode,
    output t_parse_state      o_next,
    output t_result           o_result
);

    always_comb begin
        t_parse_state      ns;
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic [ERR_W-1:0]  bad;
        logic              checked;
        logic              hdr_done;
        logic              box_done;
        logic              complete;
        logic              sg;
        logic [LEN_W-1:0]  plen;
        logic [HIDX_W-1:0] idx_inc;
        logic [HLEN_W-1:0] len_inc;
        logic [LEN_W-1:0]  hl64;
        logic [HLEN_W:0]   want_len;
        logic [HLEN_W:0]   want_total;
        logic [TYPE_W-1:0] want_type;
        logic [BYTE_W-1:0] want_byte;
        logic              size_zero;
        logic              size_short;
        logic              size_exact;
        logic              size_want;

        ns         = i_state;
        kind       = KIND_IGNORED;
        err        = ERR_NONE;
        hdr_done   = 1'b0;
        box_done   = 1'b0;
        complete   = 1'b0;
        sg         = 1'b0;
        plen       = '0;
        checked    = i_mode && (i_state.box_pos != POS_BARE);
        bad        = (i_state.box_pos == POS_SIG) ? ERR_BAD_SIG : ERR_BAD_FTYP;
        idx_inc    = i_state.hdr_idx + 5'd1;
        len_inc    = i_state.hdr_len + 6'd1;
        want_len   = (i_state.box_pos == POS_SIG) ? SIG_LEN : FTYP_LEN;
        want_type  = (i_state.box_pos == POS_SIG) ? TYPE_SIG : TYPE_FTYP;
        want_byte  = (i_state.box_pos == POS_SIG) ? sig_byte(i_state.pay_idx[1:0])
                                                  : ftyp_byte(i_state.pay_idx);
        hl64       = '0;
        want_total = '0;
        size_zero  = 1'b0;
        size_short = 1'b0;
        size_exact = 1'b0;
        size_want  = 1'b0;

        if (i_state.err == ERR_NONE) begin
            // Gather header fields or count down the payload
            unique case (i_state.phase)
                PH_SIZE: begin
                    kind        = KIND_SIZE;
                    ns.size_acc = {i_state.size_acc[LEN_W-BYTE_W-1:0], i_byte};
                    ns.hdr_idx  = idx_inc;
                    ns.hdr_len  = len_inc;
                    if (idx_inc == SIZE_BYTES) begin
                        ns.hdr_idx = '0;
                        ns.phase   = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    kind         = KIND_TYPE;
                    ns.type_word = {i_state.type_word[TYPE_W-BYTE_W-1:0], i_byte};
                    ns.hdr_idx   = idx_inc;
                    ns.hdr_len   = len_inc;
                    if (idx_inc == TYPE_BYTES) begin
                        ns.hdr_idx = '0;
                        if (i_state.size_acc == SIZE_LARGE) begin
                            ns.size_acc = '0;
                            ns.phase    = PH_LARGE;
                        end else if (ns.type_word == TYPE_UUID) begin
                            ns.phase = PH_EXT;
                        end else begin
                            complete = 1'b1;
                        end
                    end
                end
                PH_LARGE: begin
                    kind        = KIND_LARGE;
                    ns.size_acc = {i_state.size_acc[LEN_W-BYTE_W-1:0], i_byte};
                    ns.hdr_idx  = idx_inc;
                    ns.hdr_len  = len_inc;
                    if (idx_inc == LARGE_BYTES) begin
                        ns.hdr_idx = '0;
                        if (i_state.type_word == TYPE_UUID) begin
                            ns.phase = PH_EXT;
                        end else begin
                            complete = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    kind       = KIND_EXT;
                    ns.hdr_idx = idx_inc;
                    ns.hdr_len = len_inc;
                    if (idx_inc == EXT_BYTES) begin
                        ns.hdr_idx = '0;
                        complete   = 1'b1;
                    end
                end
                default: begin
                    kind = KIND_PAYLOAD;
                    sg   = !i_state.runs_to_end;
                    if (checked && (i_byte != want_byte)) begin
                        err = bad;
                    end
                    if (i_state.pay_idx != PAY_IDX_MAX) begin
                        ns.pay_idx = i_state.pay_idx + 4'd1;
                    end
                    if (!i_state.runs_to_end) begin
                        if (i_state.pay_rem != '0) begin
                            ns.pay_rem = i_state.pay_rem - 64'd1;
                        end
                        box_done = (i_state.pay_rem[LEN_W-1:1] == '0);
                    end else begin
                        box_done = i_end;
                    end
                end
            endcase

            // Work out the payload length once the header is complete
            if (complete) begin
                hdr_done   = 1'b1;
                hl64       = {{(LEN_W-HLEN_W){1'b0}}, ns.hdr_len};
                want_total = {1'b0, ns.hdr_len} + want_len;
                size_zero  = (ns.size_acc == '0);
                size_short = (ns.size_acc < hl64);
                size_exact = (ns.size_acc == hl64);
                size_want  = (ns.size_acc == {{(LEN_W-HLEN_W-1){1'b0}}, want_total});
                if (!size_zero) begin
                    if (size_short) begin
                        err = ERR_SIZE;
                    end else begin
                        ns.pay_rem = ns.size_acc - hl64;
                        sg         = 1'b1;
                        plen       = ns.pay_rem;
                    end
                end else begin
                    ns.runs_to_end = 1'b1;
                    ns.pay_rem     = '0;
                end
                if ((err == ERR_NONE) && checked) begin
                    priority if (ns.type_word != want_type) begin
                        err = bad;
                    end else if (size_zero) begin
                        err = ERR_SIZE;
                    end else begin
                        err = size_want ? ERR_NONE : bad;
                    end
                end
                if (err == ERR_NONE) begin
                    ns.phase   = PH_PAYLOAD;
                    ns.pay_idx = '0;
                    box_done   = size_zero ? i_end : size_exact;
                end
            end

            // Check how the stream ends
            if ((err == ERR_NONE) && i_end) begin
                priority if (!box_done && (ns.phase != PH_PAYLOAD)) begin
                    err = ERR_HEADER;
                end else if (!box_done) begin
                    err = ERR_TRUNCATED;
                end else begin
                    err = (i_mode && (i_state.box_pos == POS_SIG)) ? ERR_HEADER : ERR_NONE;
                end
            end

            // Latch the error or count the box
            if (err != ERR_NONE) begin
                ns.err   = err;
                hdr_done = 1'b0;
                box_done = 1'b0;
                plen     = '0;
            end else if (box_done && (i_state.box_cnt != COUNT_MAX)) begin
                ns.box_cnt = i_state.box_cnt + 16'd1;
            end
        end

        o_result.data_byte      = i_byte;
        o_result.byte_kind      = kind;
        o_result.box_type       = ns.type_word;
        o_result.header_done    = hdr_done;
        o_result.size_given     = sg;
        o_result.payload_length = plen;
        o_result.box_done       = box_done;
        o_result.box_count      = ns.box_cnt;
        o_result.error_code     = ns.err;
        o_result.stream_ok      = i_end && (ns.err == ERR_NONE);

        // Advance to the next box, or restart at the end of the stream
        o_next = ns;
        if (box_done) begin
            if (ns.box_pos != POS_BARE) begin
                o_next.box_pos = ns.box_pos + 2'd1;
            end
            o_next = clear_box(o_next);
        end
        if (i_end) begin
            o_next = STATE_RESET;
        end
    end

endmodule

[design/cbsp_out_stage.sv]
// Result register of the box stream parser, holding one request until it is taken.
module cbsp_out_stage import cbsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_result           i_result,
    output logic              o_space,
    cbsp_out_if.source        o_out
);

    logic    r_valid;
    t_result r_result;

    // Hold the request until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_space              = !r_valid || o_out.ready;
    assign o_out.valid          = r_valid;
    assign o_out.data_byte      = r_result.data_byte;
    assign o_out.byte_kind      = r_result.byte_kind;
    assign o_out.box_type       = r_result.box_type;
    assign o_out.header_done    = r_result.header_done;
    assign o_out.size_given     = r_result.size_given;
    assign o_out.payload_length = r_result.payload_length;
    assign o_out.box_done       = r_result.box_done;
    assign o_out.box_count      = r_result.box_count;
    assign o_out.error_code     = r_result.error_code;
    assign o_out.stream_ok      = r_result.stream_ok;

endmodule

[design/cbsp_checker.sv]
// Port-level checks of the box stream parser and their binding to the top level.
module cbsp_checker import cbsp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [BYTE_W-1:0]  i_data_byte,
    input logic [KIND_W-1:0]  i_byte_kind,
    input logic               i_header_done,
    input logic               i_size_given,
    input logic [LEN_W-1:0]   i_payload_length,
    input logic               i_box_done,
    input logic [ERR_W-1:0]   i_error_code
);

    logic w_out_fire;
    assign w_out_fire = i_out_valid && i_out_ready;

    // A stalled result request stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_data_byte) && $stable(i_byte_kind)))
        else $error("result request changed while stalled");

    // Header and box completion never come with an error or an ignored byte
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && (i_header_done || i_box_done)) |->
            ((i_error_code == ERR_NONE) && (i_byte_kind != KIND_IGNORED)))
        else $error("completion flagged together with an error");

    // An ignored byte is only ever reported under a latched error
    a_ignored_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && (i_byte_kind == KIND_IGNORED)) |-> (i_error_code != ERR_NONE))
        else $error("byte ignored without a latched error");

    // A payload length is only shown on a completed, sized header
    a_plen_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && (i_payload_length != '0)) |-> (i_header_done && i_size_given))
        else $error("payload length shown outside a sized header");

endmodule

bind container_box_stream_parser_core cbsp_checker u_cbsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_data_byte      (o_out.data_byte),
    .i_byte_kind      (o_out.byte_kind),
    .i_header_done    (o_out.header_done),
    .i_size_given     (o_out.size_given),
    .i_payload_length (o_out.payload_length),
    .i_box_done       (o_out.box_done),
    .i_error_code     (o_out.error_code)
);
